### rtl/iuhf_pkg.sv
`default_nettype none

package iuhf_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;
    localparam int unsigned QUEUE_DEPTH_DEF     = 4;

    localparam logic [15:0] TYPE_VLAN = 16'h8100;
    localparam logic [15:0] TYPE_QINQ = 16'h88A8;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int unsigned ETH_TYPE_END     = 14;
    localparam int unsigned TAG_LEN          = 4;
    localparam int unsigned IP_HDR_LEN       = 20;
    localparam int unsigned IP_PROTO_REL     = 9;
    localparam int unsigned IP_TOTLEN_LO_REL = 3;

    localparam int unsigned ACC_W = 20;

    typedef enum logic [1:0] {
        CLASS_NOT_IP   = 2'd0,
        CLASS_IP_OTHER = 2'd1,
        CLASS_UDP      = 2'd2,
        CLASS_TRUNC    = 2'd3
    } t_frame_class;

    // Per-frame summary handed from the parser to the finishing stage
    typedef struct packed {
        t_frame_class         frame_class;
        logic [10:0]          ip_offset;
        logic [15:0]          ip_total_length;
        logic [ACC_W-1:0]     hdr_sum;
    } t_frame_rec;

endpackage

`default_nettype wire

### rtl/iuhf_front.sv
`default_nettype none

module iuhf_front #(
    parameter int unsigned MAX_FRAME_BYTES = 2048
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_last_byte,
    output logic                     o_rec_push,
    output iuhf_pkg::t_frame_rec     o_rec
);
    import iuhf_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_FRAME_BYTES - 1);

    typedef enum logic [4:0] {
        ST_ETH    = 5'b00001,
        ST_IP     = 5'b00010,
        ST_DONE   = 5'b00100,
        ST_NOT_IP = 5'b01000,
        ST_LOST   = 5'b10000
    } t_stage;

    t_stage             r_stage, n_stage, m_stage;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [7:0]         r_type_hi, n_type_hi;
    logic [POS_W-1:0]   r_nho, n_nho;
    logic [POS_W-1:0]   r_hoff, n_hoff;
    logic [7:0]         r_proto, n_proto;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [7:0]         r_hold, n_hold;

    logic [15:0]        type_word;
    logic [POS_W-1:0]   rel;
    logic [POS_W:0]     frame_len;
    t_frame_rec         rec;

    assign type_word = {r_type_hi, i_data_byte};
    assign rel       = r_pos - r_hoff;
    assign frame_len = {1'b0, r_pos} + (POS_W+1)'(1);

    always_comb begin
        n_pos     = r_pos;
        n_type_hi = r_type_hi;
        n_nho     = r_nho;
        n_hoff    = r_hoff;
        n_proto   = r_proto;
        n_acc     = r_acc;
        n_hold    = r_hold;
        m_stage   = r_stage;
        rec       = '0;

        if (r_stage == ST_ETH) begin
            if ({1'b0, r_pos} + (POS_W+1)'(2) == {1'b0, r_nho}) begin
                n_type_hi = i_data_byte;
            end else if ({1'b0, r_pos} + (POS_W+1)'(1) == {1'b0, r_nho}) begin
                if (type_word inside {TYPE_VLAN, TYPE_QINQ}) begin
                    if ({1'b0, r_nho} + (POS_W+1)'(TAG_LEN) > {1'b0, POS_TOP}) begin
                        m_stage = ST_LOST;
                    end else begin
                        n_nho = r_nho + POS_W'(TAG_LEN);
                    end
                end else if (type_word == TYPE_IPV4) begin
                    n_hoff  = r_nho;
                    m_stage = ST_IP;
                end else begin
                    m_stage = ST_NOT_IP;
                end
            end
        end else if (r_stage == ST_IP && r_pos >= r_hoff &&
                     rel < POS_W'(IP_HDR_LEN)) begin
            if (rel == POS_W'(IP_PROTO_REL)) begin
                n_proto = i_data_byte;
            end
            if (!rel[0]) begin
                n_hold = i_data_byte;
            end else if (rel != POS_W'(IP_TOTLEN_LO_REL)) begin
                n_acc = r_acc + ACC_W'({r_hold, i_data_byte});
            end
            if (rel == POS_W'(IP_HDR_LEN - 1)) begin
                m_stage = ST_DONE;
            end
        end

        // stop parsing once the byte window is exhausted
        if (r_pos >= POS_TOP && (m_stage == ST_ETH || m_stage == ST_IP)) begin
            m_stage = ST_LOST;
        end

        n_stage = m_stage;

        case (m_stage)
            ST_NOT_IP: rec.frame_class = CLASS_NOT_IP;
            ST_DONE: begin
                rec.frame_class     = (n_proto == PROTO_UDP) ? CLASS_UDP : CLASS_IP_OTHER;
                rec.ip_offset       = 11'(n_hoff);
                rec.ip_total_length = (frame_len >= {1'b0, n_hoff}) ?
                                      16'(frame_len - {1'b0, n_hoff}) : 16'd0;
                rec.hdr_sum         = n_acc;
            end
            default:   rec.frame_class = CLASS_TRUNC;
        endcase

        if (i_last_byte) begin
            n_pos     = '0;
            n_stage   = ST_ETH;
            n_type_hi = '0;
            n_nho     = POS_W'(ETH_TYPE_END);
            n_hoff    = '0;
            n_proto   = '0;
            n_acc     = '0;
            n_hold    = '0;
        end else if (r_pos < POS_TOP) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= ST_ETH;
            r_pos     <= '0;
            r_type_hi <= '0;
            r_nho     <= POS_W'(ETH_TYPE_END);
            r_hoff    <= '0;
            r_proto   <= '0;
            r_acc     <= '0;
            r_hold    <= '0;
        end else if (i_accept) begin
            r_stage   <= n_stage;
            r_pos     <= n_pos;
            r_type_hi <= n_type_hi;
            r_nho     <= n_nho;
            r_hoff    <= n_hoff;
            r_proto   <= n_proto;
            r_acc     <= n_acc;
            r_hold    <= n_hold;
        end
    end

    assign o_rec_push = i_accept && i_last_byte;
    assign o_rec      = rec;

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_ETH) |-> (r_nho <= POS_TOP))
        else $error("next header offset beyond byte window");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_push |=> (r_pos == '0 && r_stage == ST_ETH))
        else $error("parser did not restart after frame end");

endmodule

`default_nettype wire

### rtl/iuhf_queue.sv
`default_nettype none

module iuhf_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire iuhf_pkg::t_frame_rec i_rec,
    input  wire logic                i_pop,
    output iuhf_pkg::t_frame_rec     o_rec,
    output logic                     o_empty,
    output logic                     o_full
);
    import iuhf_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_frame_rec         r_slot [DEPTH];
    logic [AW-1:0]      r_wr, n_wr;
    logic [AW-1:0]      r_rd, n_rd;
    logic [CW-1:0]      r_count, n_count;
    logic               wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_rec   = r_slot[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (wr_en) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (rd_en) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr] <= i_rec;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count overflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not advance on write");

endmodule

`default_nettype wire

### rtl/iuhf_back.sv
`default_nettype none

module iuhf_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire iuhf_pkg::t_frame_rec i_rec,
    input  wire logic                i_rec_empty,
    output logic                     o_rec_pop,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output logic [1:0]               o_frame_class,
    output logic [10:0]              o_ip_offset,
    output logic [15:0]              o_ip_total_length,
    output logic [15:0]              o_udp_length,
    output logic [15:0]              o_ip_checksum
);
    import iuhf_pkg::*;

    logic               r_valid;
    logic [1:0]         r_class;
    logic [10:0]        r_off;
    logic [15:0]        r_tot;
    logic [15:0]        r_ulen;
    logic [15:0]        r_ck;

    logic               take;
    logic               is_udp;
    logic [ACC_W:0]     sum;
    logic [16:0]        fold1;
    logic [15:0]        fold2;
    logic [15:0]        n_ulen;
    logic [15:0]        n_ck;

    assign take   = !i_rec_empty && (!r_valid || i_pop);
    assign is_udp = (i_rec.frame_class == CLASS_UDP);

    // Fold the header sum plus the computed total length to 16 bits
    always_comb begin
        sum    = {1'b0, i_rec.hdr_sum} + (ACC_W+1)'(i_rec.ip_total_length);
        fold1  = 17'(sum[ACC_W:16]) + {1'b0, sum[15:0]};
        fold2  = fold1[15:0] + 16'(fold1[16]);
        n_ck   = is_udp ? ~fold2 : 16'd0;
        n_ulen = (is_udp && i_rec.ip_total_length >= 16'(IP_HDR_LEN)) ?
                 i_rec.ip_total_length - 16'(IP_HDR_LEN) : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_class <= i_rec.frame_class;
            r_off   <= i_rec.ip_offset;
            r_tot   <= i_rec.ip_total_length;
            r_ulen  <= n_ulen;
            r_ck    <= n_ck;
        end
    end

    assign o_rec_pop         = take;
    assign o_empty           = !r_valid;
    assign o_frame_class     = r_class;
    assign o_ip_offset       = r_off;
    assign o_ip_total_length = r_tot;
    assign o_udp_length      = r_ulen;
    assign o_ip_checksum     = r_ck;

    a_udp_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_class != CLASS_UDP) |-> (r_ulen == '0 && r_ck == '0))
        else $error("UDP fields set on a non-UDP item");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_valid)
        else $error("output register not loaded");

endmodule

`default_nettype wire

### rtl/ipv4_udp_header_fixup.sv
// IPv4/UDP header fixup: parses one Ethernet frame per byte stream and
// reports lengths and, for UDP frames, the IPv4 header checksum for it.
//
// Input channel: one frame byte per item on i_data_byte, i_last_byte high
// on the final byte. A byte is taken on a clock edge with push high and
// full low. 802.1Q / 802.1AD tags are skipped within the byte window.
// Result channel: one item per frame. It is on the o_ ports while empty is
// low and leaves on an edge with pop high.
// Throughput: one byte per cycle, set by the parser, while full is low.
// Result path: with the output register free, the summary enters the queue
// on the edge that takes the last byte, and the checksum fold loads the
// output register from the queue on the next.
// Stall: a stalled receiver holds the output register; further frame
// summaries collect in the QUEUE_DEPTH-entry queue, and full rises only
// when that queue is full.
// Reset: synchronous, active low; clears the parser to the Ethernet header
// stage, empties the queue and the output register.
`default_nettype none

module ipv4_udp_header_fixup #(
    parameter int unsigned MAX_FRAME_BYTES = iuhf_pkg::MAX_FRAME_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH     = iuhf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_last_byte,
    output logic                empty,
    input  wire logic           pop,
    output logic [1:0]          o_frame_class,
    output logic [10:0]         o_ip_offset,
    output logic [15:0]         o_ip_total_length,
    output logic [15:0]         o_udp_length,
    output logic [15:0]         o_ip_checksum
);
    import iuhf_pkg::*;

    logic           accept;
    logic           rec_push;
    t_frame_rec     rec_in;
    t_frame_rec     rec_head;
    logic           rec_empty;
    logic           rec_full;
    logic           rec_pop;

    // Hold off every byte while the summary queue has no room
    assign full   = rec_full;
    assign accept = push && !rec_full;

    iuhf_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_rec_push  (rec_push),
        .o_rec       (rec_in)
    );

    iuhf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec_in),
        .i_pop   (rec_pop),
        .o_rec   (rec_head),
        .o_empty (rec_empty),
        .o_full  (rec_full)
    );

    iuhf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rec             (rec_head),
        .i_rec_empty       (rec_empty),
        .o_rec_pop         (rec_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_frame_class     (o_frame_class),
        .o_ip_offset       (o_ip_offset),
        .o_ip_total_length (o_ip_total_length),
        .o_udp_length      (o_udp_length),
        .o_ip_checksum     (o_ip_checksum)
    );

endmodule

`default_nettype wire
